### rtl/mlfq_process_scheduler_assert.svh
// ----------------------------------------------------------------------------
// mlfq process scheduler assertion macros
// concurrent checks sampled on the rising clock edge, off while reset is low
// ----------------------------------------------------------------------------
`ifndef MLFQ_PROCESS_SCHEDULER_ASSERT_SVH
`define MLFQ_PROCESS_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define MLFQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MLFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// shared types, codes and constants of the mlfq process scheduler
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int DEF_NUM_PROCS  = 16;
  localparam int DEF_NUM_LEVELS = 4;

  localparam int PID_W   = 4;
  localparam int QUANT_W = 8;
  localparam int TICK_W  = 8;
  localparam int BINT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [QUANT_W-1:0] QUANT0_RST = 8'd2;
  localparam logic [QUANT_W-1:0] QUANT1_RST = 8'd4;
  localparam logic [QUANT_W-1:0] QUANT2_RST = 8'd6;
  localparam logic [QUANT_W-1:0] QUANT3_RST = 8'd8;
  localparam logic [BINT_W-1:0]  BINT_RST   = 16'd100;
  localparam logic [PID_W-1:0]   IDLE_RST   = 4'd0;
  localparam logic [TICK_W-1:0]  TICK_MAX   = 8'd255;

  // opcodes
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_PICK = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 3'd5;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [PID_W-1:0] proc_id;
    logic             proc_dead;
    logic             current_valid;
    logic [PID_W-1:0] current_id;
    logic             current_running;
  } in_item_t;

  typedef struct packed {
    logic             picked_valid;
    logic [PID_W-1:0] picked_id;
    logic             reschedule;
    logic             boosted;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ENQ,
    S_PICK,
    S_TICK,
    S_BST_LVL,
    S_BST_CLR,
    S_BST_NXT,
    S_BST_CUR,
    S_DONE
  } state_t;

endpackage

### rtl/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mlfq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/mlfq_pstate.sv
// ----------------------------------------------------------------------------
// mlfq_pstate
// per-process level and used ticks, ram plus valid bits (invalid reads zero)
// ----------------------------------------------------------------------------
module mlfq_pstate
  import mlfq_pkg::*;
#(
  parameter int NUM_PROCS  = DEF_NUM_PROCS,
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(NUM_PROCS)-1:0]  raddr,
  input  logic                          we,
  input  logic [$clog2(NUM_PROCS)-1:0]  waddr,
  input  logic [$clog2(NUM_LEVELS)-1:0] wlevel,
  input  logic [TICK_W-1:0]             wticks,
  output logic [$clog2(NUM_LEVELS)-1:0] rlevel,
  output logic [TICK_W-1:0]             rticks
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int DW = LW + TICK_W;

  logic [NUM_PROCS-1:0] vld_r;
  logic                 rd_vld_r;
  logic [DW-1:0]        rdata;

  mlfq_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({wlevel, wticks}),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  // never-written entries read as the reset value
  assign rlevel = rd_vld_r ? rdata[DW-1:TICK_W] : '0;
  assign rticks = rd_vld_r ? rdata[TICK_W-1:0] : '0;

endmodule

### rtl/mlfq_process_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler: multilevel feedback queue over a fixed set of ids
// one transaction at a time: a new input is accepted only after the last result has
// gone into the output register; enqueue, pick and tick each walk their own states
// a boost walks every queued process of levels 1 and up, level by level
// a stalled result holds the done state; reset empties all queues, clears process state
// ----------------------------------------------------------------------------
`include "mlfq_process_scheduler_assert.svh"

module mlfq_process_scheduler
  import mlfq_pkg::*;
#(
  parameter int NUM_PROCS  = DEF_NUM_PROCS,
  parameter int NUM_LEVELS = DEF_NUM_LEVELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDW = $clog2(NUM_PROCS);
  localparam int LW  = $clog2(NUM_LEVELS);

  // control state
  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic out_valid_r, out_valid_nxt;

  // queue heads and tails per level, link ram holds the fifo chains
  logic [IDW-1:0] head_r [NUM_LEVELS];
  logic [IDW-1:0] head_nxt [NUM_LEVELS];
  logic [IDW-1:0] tail_r [NUM_LEVELS];
  logic [IDW-1:0] tail_nxt [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ne_r, ne_nxt;
  logic [NUM_PROCS-1:0] queued_r, queued_nxt;
  logic [BINT_W-1:0] bcnt_r, bcnt_nxt;

  // level cursor for pick and boost, walker for the boost
  logic [LW:0] lvl_r, lvl_nxt;
  logic [IDW-1:0] walk_r, walk_nxt;

  // configuration
  logic [QUANT_W-1:0] quant_r [4];
  logic [BINT_W-1:0] bint_r;
  logic [PID_W-1:0] idle_r;

  // link ram port
  logic nl_we;
  logic [IDW-1:0] nl_waddr, nl_wdata, nl_raddr, nl_rdata;

  // process state ram port
  logic ps_we;
  logic [IDW-1:0] ps_waddr, ps_raddr;
  logic [LW-1:0] ps_wlevel, ps_rlevel;
  logic [TICK_W-1:0] ps_wticks, ps_rticks;

  // decode of the held transaction
  logic [IDW-1:0] pid_x, cur_x;
  logic pid_ok, cur_ok, enq_go;
  logic [BINT_W:0] cnt_ext;
  logic boost_hit;
  logic any_ne;
  logic [LW-1:0] pick_lvl;
  logic [LW-1:0] lvl_i;
  logic lvl_end;
  logic pick_last;
  logic out_free;

  // tick arithmetic on the read-back process state
  logic [TICK_W-1:0] t_inc;
  logic [QUANT_W-1:0] q_sel;
  logic demote;
  logic [LW-1:0] lvl_dem;

  mlfq_ram #(
    .WIDTH (IDW),
    .DEPTH (NUM_PROCS)
  ) u_link (
    .clk   (clk),
    .we    (nl_we),
    .waddr (nl_waddr),
    .wdata (nl_wdata),
    .raddr (nl_raddr),
    .rdata (nl_rdata)
  );

  mlfq_pstate #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_pstate (
    .clk    (clk),
    .rst_n  (rst_n),
    .raddr  (ps_raddr),
    .we     (ps_we),
    .waddr  (ps_waddr),
    .wlevel (ps_wlevel),
    .wticks (ps_wticks),
    .rlevel (ps_rlevel),
    .rticks (ps_rticks)
  );

  assign pid_x  = IDW'(item_r.proc_id);
  assign cur_x  = IDW'(item_r.current_id);
  assign pid_ok = 32'(item_r.proc_id) < NUM_PROCS;
  // an id beyond the table means no current process
  assign cur_ok = item_r.current_valid && (32'(item_r.current_id) < NUM_PROCS);
  assign enq_go = pid_ok && !item_r.proc_dead && !queued_r[pid_x];

  assign cnt_ext   = {1'b0, bcnt_r} + {{BINT_W{1'b0}}, 1'b1};
  assign boost_hit = cnt_ext >= {1'b0, bint_r};

  assign any_ne = |ne_r;
  always_comb begin
    pick_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ne_r[i]) begin
        pick_lvl = LW'(i);
      end
    end
  end
  assign pick_last = head_r[pick_lvl] == tail_r[pick_lvl];

  assign lvl_i   = lvl_r[LW-1:0];
  assign lvl_end = lvl_r == (LW+1)'(NUM_LEVELS);

  // levels from three up share the last quantum register
  assign q_sel   = (32'(ps_rlevel) < 3) ? quant_r[2'(ps_rlevel)] : quant_r[3];
  assign t_inc   = (ps_rticks != TICK_MAX) ? ps_rticks + 1'b1 : ps_rticks;
  assign demote  = t_inc >= q_sel;
  assign lvl_dem = (32'(ps_rlevel) < NUM_LEVELS - 1) ? ps_rlevel + 1'b1 : ps_rlevel;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = state_r != S_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (item_r.opcode)
          OP_ENQ:  state_nxt = enq_go ? S_ENQ : S_DONE;
          OP_PICK: state_nxt = (any_ne && !pick_last) ? S_PICK : S_DONE;
          OP_TICK: begin
            if (boost_hit) begin
              state_nxt = S_BST_LVL;
            end else if (cur_ok && item_r.current_running) begin
              state_nxt = S_TICK;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_ENQ, S_PICK, S_TICK, S_BST_CUR: state_nxt = (state_r == S_BST_CUR) ? S_DONE : S_DONE;
      S_BST_LVL: begin
        if (lvl_end) begin
          state_nxt = S_BST_CUR;
        end else if (ne_r[lvl_i]) begin
          state_nxt = S_BST_CLR;
        end
      end
      S_BST_CLR: state_nxt = (walk_r == tail_r[lvl_i]) ? S_BST_LVL : S_BST_NXT;
      S_BST_NXT: state_nxt = S_BST_CLR;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    item_nxt     = item_r;
    res_nxt      = res_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    ne_nxt       = ne_r;
    queued_nxt   = queued_r;
    bcnt_nxt     = bcnt_r;
    lvl_nxt      = lvl_r;
    walk_nxt     = walk_r;
    nl_we        = 1'b0;
    nl_waddr     = tail_r[0];
    nl_wdata     = pid_x;
    nl_raddr     = walk_r;
    ps_raddr     = (item_r.opcode == OP_ENQ) ? pid_x : cur_x;
    ps_we        = 1'b0;
    ps_waddr     = cur_x;
    ps_wlevel    = '0;
    ps_wticks    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
        end
      end
      S_EXEC: begin
        res_nxt = '0;
        case (item_r.opcode)
          OP_PICK: begin
            if (any_ne) begin
              res_nxt.picked_valid = 1'b1;
              res_nxt.picked_id    = PID_W'(head_r[pick_lvl]);
              queued_nxt[head_r[pick_lvl]] = 1'b0;
              lvl_nxt  = {1'b0, pick_lvl};
              nl_raddr = head_r[pick_lvl];
              if (pick_last) begin
                ne_nxt[pick_lvl] = 1'b0;
              end
            end
          end
          OP_TICK: begin
            if (boost_hit) begin
              bcnt_nxt = '0;
              lvl_nxt  = (LW+1)'(1);
              res_nxt.reschedule = 1'b1;
              res_nxt.boosted    = 1'b1;
            end else begin
              bcnt_nxt = cnt_ext[BINT_W-1:0];
            end
          end
          default: ;
        endcase
      end
      S_ENQ: begin
        // append at the tail of the stored level
        queued_nxt[pid_x] = 1'b1;
        tail_nxt[ps_rlevel] = pid_x;
        if (ne_r[ps_rlevel]) begin
          nl_we    = 1'b1;
          nl_waddr = tail_r[ps_rlevel];
          nl_wdata = pid_x;
        end else begin
          head_nxt[ps_rlevel] = pid_x;
          ne_nxt[ps_rlevel]   = 1'b1;
        end
      end
      S_PICK: begin
        head_nxt[lvl_i] = nl_rdata;
      end
      S_TICK: begin
        ps_we     = 1'b1;
        ps_waddr  = cur_x;
        ps_wlevel = demote ? lvl_dem : ps_rlevel;
        ps_wticks = demote ? '0 : t_inc;
        res_nxt.reschedule = demote;
      end
      S_BST_LVL: begin
        if (!lvl_end) begin
          if (ne_r[lvl_i]) begin
            walk_nxt = head_r[lvl_i];
          end else begin
            lvl_nxt = lvl_r + 1'b1;
          end
        end
      end
      S_BST_CLR: begin
        // clear the walked process, splice the whole chain once at its tail
        ps_we    = 1'b1;
        ps_waddr = walk_r;
        nl_raddr = walk_r;
        if (walk_r == tail_r[lvl_i]) begin
          if (ne_r[0]) begin
            nl_we    = 1'b1;
            nl_waddr = tail_r[0];
            nl_wdata = head_r[lvl_i];
          end else begin
            head_nxt[0] = head_r[lvl_i];
            ne_nxt[0]   = 1'b1;
          end
          tail_nxt[0]   = tail_r[lvl_i];
          ne_nxt[lvl_i] = 1'b0;
          lvl_nxt       = lvl_r + 1'b1;
        end
      end
      S_BST_NXT: begin
        walk_nxt = nl_rdata;
      end
      S_BST_CUR: begin
        // the idle process keeps its level across a boost
        if (cur_ok && (item_r.current_id != idle_r)) begin
          ps_we    = 1'b1;
          ps_waddr = cur_x;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ne_r        <= '0;
      queued_r    <= '0;
      bcnt_r      <= '0;
      lvl_r       <= '0;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ne_r        <= ne_nxt;
      queued_r    <= queued_nxt;
      bcnt_r      <= bcnt_nxt;
      lvl_r       <= lvl_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    walk_r     <= walk_nxt;
  end

  // register writes, taken whenever the enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r[0] <= QUANT0_RST;
      quant_r[1] <= QUANT1_RST;
      quant_r[2] <= QUANT2_RST;
      quant_r[3] <= QUANT3_RST;
      bint_r     <= BINT_RST;
      idle_r     <= IDLE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_QUANT0: quant_r[0] <= cfg_wdata[QUANT_W-1:0];
        CFG_QUANT1: quant_r[1] <= cfg_wdata[QUANT_W-1:0];
        CFG_QUANT2: quant_r[2] <= cfg_wdata[QUANT_W-1:0];
        CFG_QUANT3: quant_r[3] <= cfg_wdata[QUANT_W-1:0];
        CFG_BOOST:  bint_r     <= cfg_wdata[BINT_W-1:0];
        CFG_IDLE:   idle_r     <= cfg_wdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new result only comes out of the done state
  `MLFQ_ASSERT_NOW(a_out_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_DONE, "result without done state")
  // after a boost walk every level below the top is empty
  `MLFQ_ASSERT_NOW(a_boost_drained, clk, rst_n, state_r == S_BST_CUR, (ne_r >> 1) == '0, "boost left a lower level non-empty")
  // an accepted transaction always starts work
  `MLFQ_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && !in_stall, state_r == S_EXEC, "accepted transaction not decoded")

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// mlfq process scheduler testbench
// directed table then random enqueue/pick/tick traffic with random idling on
// both channels; every result is checked against a behavioral scheduler model
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import mlfq_pkg::*;

  localparam int NPROC   = 16;
  localparam int NLVL    = 4;
  localparam int WDOG    = 20000;
  localparam int N_RAND  = 1050;
  localparam int IN_W    = $bits(in_item_t);
  localparam logic [1:0] OP_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mlfq_process_scheduler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // scheduler model state
  logic [7:0]  m_quant [4];
  logic [15:0] m_bint;
  logic [3:0]  m_idle;
  logic [3:0]  m_head [NLVL];
  logic [3:0]  m_tail [NLVL];
  logic        m_nonempty [NLVL];
  logic [3:0]  m_next [NPROC];
  logic [1:0]  m_level [NPROC];
  logic [7:0]  m_ticks [NPROC];
  logic        m_queued [NPROC];
  logic [15:0] m_bcnt;

  out_item_t sched_q [$];
  int errors = 0;
  int idle_pct = 0;    // sender idle percentage
  int stall_pct = 0;   // receiver stall percentage
  int quiet = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t exp);
    $display("mismatch %s: got %b/%h/%b/%b exp %b/%h/%b/%b", what,
             got.picked_valid, got.picked_id, got.reschedule, got.boosted,
             exp.picked_valid, exp.picked_id, exp.reschedule, exp.boosted);
    errors++;
  endtask

  function automatic void model_reset();
    m_quant[0] = QUANT0_RST; m_quant[1] = QUANT1_RST;
    m_quant[2] = QUANT2_RST; m_quant[3] = QUANT3_RST;
    m_bint = BINT_RST; m_idle = IDLE_RST; m_bcnt = '0;
    for (int l = 0; l < NLVL; l++) begin
      m_head[l] = '0; m_tail[l] = '0; m_nonempty[l] = 1'b0;
    end
    for (int p = 0; p < NPROC; p++) begin
      m_next[p] = '0; m_level[p] = '0; m_ticks[p] = '0; m_queued[p] = 1'b0;
    end
  endfunction

  function automatic void fifo_push(input int l, input logic [3:0] id);
    if (m_nonempty[l]) begin
      m_next[m_tail[l]] = id;
      m_tail[l] = id;
    end else begin
      m_head[l] = id; m_tail[l] = id; m_nonempty[l] = 1'b1;
    end
  endfunction

  function automatic logic [3:0] fifo_take(input int l);
    logic [3:0] id;
    id = m_head[l];
    if (m_head[l] == m_tail[l]) m_nonempty[l] = 1'b0;
    else m_head[l] = m_next[id];
    return id;
  endfunction

  function automatic out_item_t schedule_step(input in_item_t it);
    out_item_t r;
    logic [16:0] cnt;
    int t, l;
    logic [3:0] id;
    r = '0;
    case (it.opcode)
      OP_ENQ: begin
        if (!it.proc_dead && !m_queued[it.proc_id]) begin
          fifo_push(m_level[it.proc_id], it.proc_id);
          m_queued[it.proc_id] = 1'b1;
        end
      end
      OP_PICK: begin
        for (l = 0; l < NLVL; l++) begin
          if (m_nonempty[l]) begin
            id = fifo_take(l);
            m_queued[id] = 1'b0;
            r.picked_valid = 1'b1;
            r.picked_id = id;
            break;
          end
        end
      end
      OP_TICK: begin
        cnt = m_bcnt + 17'd1;
        if (cnt >= m_bint) begin
          m_bcnt = '0;
          for (l = 1; l < NLVL; l++) begin
            while (m_nonempty[l]) begin
              id = fifo_take(l);
              m_level[id] = '0; m_ticks[id] = '0;
              fifo_push(0, id);
            end
          end
          if (it.current_valid && it.current_id != m_idle) begin
            m_level[it.current_id] = '0; m_ticks[it.current_id] = '0;
          end
          r.boosted = 1'b1; r.reschedule = 1'b1;
        end else begin
          m_bcnt = cnt[15:0];
          if (it.current_valid && it.current_running) begin
            t = m_ticks[it.current_id];
            if (t < 255) t++;
            l = m_level[it.current_id];
            if (t >= m_quant[l]) begin
              if (l < NLVL - 1) l++;
              m_level[it.current_id] = l[1:0];
              t = 0;
              r.reschedule = 1'b1;
            end
            m_ticks[it.current_id] = t[7:0];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // register write, only while nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_QUANT0: m_quant[0] = val[7:0];
      CFG_QUANT1: m_quant[1] = val[7:0];
      CFG_QUANT2: m_quant[2] = val[7:0];
      CFG_QUANT3: m_quant[3] = val[7:0];
      CFG_BOOST:  m_bint = val;
      CFG_IDLE:   m_idle = val[3:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sched_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);   // a boost walks every queued process
  endtask

  // one transaction on the input channel, with random sender gaps
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(posedge clk);
      in_valid <= 1'b0;
    end
    @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    sched_q.push_back(schedule_step(it));
    in_valid <= 1'b0;
  endtask

  function automatic in_item_t rand_item(input int mode);
    in_item_t it;
    int r;
    it = in_item_t'(IN_W'($urandom));
    r = $urandom_range(99);
    if (mode == 0) begin
      // mostly sensible traffic: enqueues, picks and ticks on running processes
      if (r < 35) it.opcode = OP_ENQ;
      else if (r < 60) it.opcode = OP_PICK;
      else if (r < 97) it.opcode = OP_TICK;
      else it.opcode = OP_NOP;
      if (it.opcode == OP_ENQ && $urandom_range(9) != 0) it.proc_dead = 1'b0;
      if (it.opcode == OP_TICK && $urandom_range(9) != 0) begin
        it.current_valid = 1'b1; it.current_running = 1'b1;
      end
    end
    return it;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (sched_q.size() == 0) begin
          report("unexpected", out_data, '0);
        end else if (out_data != sched_q[0]) begin
          report("fields", out_data, sched_q[0]);
          void'(sched_q.pop_front());
        end else begin
          void'(sched_q.pop_front());
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  typedef struct {
    in_item_t  it;
    logic      chk;   // typed-in expectation present
    out_item_t exp;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic in_item_t mk(input logic [1:0] op, input logic [3:0] pid,
                                  input logic dead, input logic cv,
                                  input logic [3:0] cid, input logic run);
    in_item_t it;
    it.opcode = op; it.proc_id = pid; it.proc_dead = dead;
    it.current_valid = cv; it.current_id = cid; it.current_running = run;
    return it;
  endfunction

  function automatic out_item_t res(input logic pv, input logic [3:0] pid,
                                    input logic rs, input logic bs);
    out_item_t r;
    r.picked_valid = pv; r.picked_id = pid; r.reschedule = rs; r.boosted = bs;
    return r;
  endfunction

  function automatic void row(input in_item_t it, input logic chk, input out_item_t e);
    dir_row_t d;
    d.it = it; d.chk = chk; d.exp = e;
    dir_tab.push_back(d);
  endfunction

  initial begin
    int phase;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // pick on empty queues after reset, then dead, fresh and repeated enqueues and a pick
    row(mk(OP_PICK, 4'hF, 1'b1, 1'b1, 4'hF, 1'b1), 1, res(0, 0, 0, 0));
    row(mk(OP_NOP, 4'hF, 1'b1, 1'b1, 4'hF, 1'b1), 1, res(0, 0, 0, 0));
    row(mk(OP_ENQ, 4'hF, 1'b1, 1'b0, 4'h0, 1'b0), 1, res(0, 0, 0, 0));  // dead
    row(mk(OP_ENQ, 4'hF, 1'b0, 1'b0, 4'h0, 1'b0), 1, res(0, 0, 0, 0));
    row(mk(OP_ENQ, 4'hF, 1'b0, 1'b1, 4'hF, 1'b1), 1, res(0, 0, 0, 0));  // already queued
    row(mk(OP_ENQ, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 1, res(0, 0, 0, 0));
    row(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 1, res(1, 4'hF, 0, 0));
    // demote 15 to level 2, with ticks while it is not running or not valid as current
    row(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'hF, 1'b1), 0, '0);
    row(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'hF, 1'b1), 1, res(0, 0, 1, 0));
    row(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'hF, 1'b0), 0, '0);
    row(mk(OP_TICK, 4'h0, 1'b0, 1'b0, 4'hF, 1'b1), 0, '0);
    for (int k = 0; k < 4; k++) row(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'hF, 1'b1), 0, '0);
    row(mk(OP_ENQ, 4'hF, 1'b0, 1'b0, 4'h0, 1'b0), 0, '0);
    row(mk(OP_ENQ, 4'h3, 1'b0, 1'b0, 4'h0, 1'b0), 0, '0);
    row(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 0, '0);
    row(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 0, '0);
    row(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 1, res(1, 4'hF, 0, 0));
    row(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0), 1, res(0, 0, 0, 0));

    foreach (dir_tab[i]) begin
      send(dir_tab[i].it);
      if (dir_tab[i].chk && sched_q[$] != dir_tab[i].exp)
        report("directed", sched_q[$], dir_tab[i].exp);
    end
    drain();

    // extremes: every tick boosts, idle id at maximum
    write_reg(CFG_BOOST, 16'd1);
    write_reg(CFG_IDLE, 16'hF);
    send(mk(OP_ENQ, 4'h5, 1'b0, 1'b0, 4'h0, 1'b0));
    send(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'hF, 1'b1));
    if (sched_q[$] != res(0, 0, 1, 1)) report("boost", sched_q[$], res(0, 0, 1, 1));
    send(mk(OP_TICK, 4'h0, 1'b0, 1'b1, 4'h5, 1'b1));
    send(mk(OP_PICK, 4'h0, 1'b0, 1'b0, 4'h0, 1'b0));
    drain();

    // random phases under several settings and idling mixes
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      case (phase)
        0: begin
          write_reg(CFG_QUANT0, 16'd1); write_reg(CFG_QUANT1, 16'd1);
          write_reg(CFG_QUANT2, 16'd1); write_reg(CFG_QUANT3, 16'd1);
          write_reg(CFG_BOOST, 16'd7);  write_reg(CFG_IDLE, 16'd0);
        end
        1: begin
          write_reg(CFG_QUANT0, 16'd255); write_reg(CFG_QUANT1, 16'd255);
          write_reg(CFG_QUANT2, 16'd255); write_reg(CFG_QUANT3, 16'd255);
          write_reg(CFG_BOOST, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_QUANT0, 16'($urandom_range(1, 4)));
          write_reg(CFG_QUANT1, 16'($urandom_range(1, 6)));
          write_reg(CFG_QUANT2, 16'($urandom_range(1, 8)));
          write_reg(CFG_QUANT3, 16'($urandom_range(1, 255)));
          write_reg(CFG_BOOST, 16'($urandom_range(1, 40)));
          write_reg(CFG_IDLE, 16'($urandom_range(0, 15)));
        end
      endcase
      for (int n = 0; n < N_RAND / 8; n++) begin
        send(rand_item(($urandom_range(9) == 0) ? 1 : 0));
        // once per phase the sender holds off until everything is back
        if (n == 60) while (sched_q.size() != 0) @(posedge clk);
      end
      drain();
    end

    idle_pct = 0; stall_pct = 0;
    repeat (20) @(posedge clk);
    if (errors == 0 && sched_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mlfq_pkg.sv
rtl/mlfq_ram.sv
rtl/mlfq_pstate.sv
rtl/mlfq_process_scheduler.sv
tb/testbench.sv
